// ----- src/rte_pkg.sv -----
`default_nettype none
package rte_pkg;
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_DEL    = 3'd1;
  localparam logic [2:0] MODE_RENEW  = 3'd2;
  localparam logic [2:0] MODE_FIRST  = 3'd3;
  localparam logic [2:0] MODE_BEST   = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UPD   = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [3:0] FULL_LIFE = 4'd10;

  // one table entry, 44 bits
  typedef struct packed {
    logic [3:0] life;
    logic [7:0] quality;
    logic [7:0] hops;
    logic [7:0] seq;
    logic [7:0] next;
    logic [7:0] dest;
  } route_t;

  // (old + snr) / 2 truncated toward zero
  function automatic logic [7:0] avg_q(input logic [7:0] old_q, input logic [7:0] snr);
    logic signed [8:0] sum;
    logic signed [8:0] half;
    sum  = $signed({old_q[7], old_q}) + $signed({snr[7], snr});
    half = (sum + {8'd0, sum[8] & sum[0]}) >>> 1;
    return half[7:0];
  endfunction
endpackage
`default_nettype wire

// ----- src/rte_mem.sv -----
`default_nettype none
module rte_mem import rte_pkg::*; #(
  parameter int AW = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire route_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output route_t             rdata
);
  route_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/route_table_engine.sv -----
`default_nettype none
// Route table engine: a compacted table of routes held in one synchronous RAM.
// Input channel s_axis_*: one request per beat; tdata packs mode, dest_addr,
// hop_addr, dest_seq, hops, link_snr from bit 0 up. Output channel m_axis_*:
// one result per request; tdata packs status, route_hop, entry_count.
// Valid routes sit in slots 0..count-1.
// Scan: a request reads slots one per cycle through the RAM's registered read.
// Add, renew, delete and first-match lookup stop the scan early on a match;
// best-quality lookup scans every valid slot, and an append passes through an
// extra state. Delete then copies every later slot down, up to TABLE_DEPTH-1.
// Clear and an add to a full table finish without a scan.
// One request is in work at a time; s_axis_tready is high only while idle.
// Reset empties the table (count 0) but RAM contents are unknown; every slot
// is fully written by add before it becomes valid, except quality, which add
// averages with the old slot, and life, which add keeps from it: a clearing
// pass after reset zeroes the RAM while no request is taken.
// When the receiver stalls, the result waits in the output register and the
// next request is not taken until it is delivered.
module route_table_engine import rte_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[2:0], dest_addr[10:3], hop_addr[18:11], dest_seq[26:19], hops[34:27],
  // link_snr[42:35], zero fill
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], route_hop[9:2], entry_count[15:10]
  output logic [15:0]      m_axis_tdata
);
  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SHFT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_APP  = 3'd6;

  logic [2:0] state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // slot whose read is issued this cycle
  logic [CW-1:0] ridx;      // slot in rdata
  logic          rvalid;
  logic [2:0] mode;
  logic [7:0] dst, hop, seq, hc, snr;
  logic [1:0] status;
  logic [7:0] rhop;
  logic signed [8:0] best;
  logic [5:0] cnt_out;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  route_t        wdata, rdata;

  rte_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {cnt_out, rhop, status};

  logic match_dh, match_ds, match_d;
  assign match_d  = rdata.dest == dst;
  assign match_dh = match_d && rdata.next == hop;
  assign match_ds = match_d && rdata.seq == seq;

  always_comb begin
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = ridx[AW-1:0];
    wdata = rdata;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = '0;
      end
      S_SCAN: begin
        if (rvalid && ridx < count) begin
          case (mode)
            MODE_ADD: if (match_dh && rdata.seq < seq) begin
              we = 1'b1;
              wdata.seq = seq;
              wdata.hops = hc;
              wdata.quality = avg_q(rdata.quality, snr);
            end
            MODE_RENEW: if (match_ds) begin
              we = 1'b1;
              wdata.life = FULL_LIFE;
            end
            default: ;
          endcase
        end
      end
      S_APP: begin
        if (rvalid) begin
          we = 1'b1;
          wdata.dest = dst;
          wdata.next = hop;
          wdata.seq = seq;
          wdata.hops = hc;
          wdata.quality = avg_q(rdata.quality, snr);
        end
      end
      S_SHFT: begin
        // rdata is slot ridx, written into ridx-1
        if (rvalid) begin
          we = 1'b1;
          waddr = AW'(ridx - 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      count  <= '0;
      idx    <= '0;
      rvalid <= 1'b0;
    end else begin
      ridx <= idx;
      case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == DEPTH_C - 1'b1) begin
            state <= S_IDLE;
            idx <= '0;
          end
        end
        S_IDLE: begin
          rvalid <= 1'b0;
          if (s_axis_tvalid) begin
            mode <= s_axis_tdata[2:0];
            dst  <= s_axis_tdata[10:3];
            hop  <= s_axis_tdata[18:11];
            seq  <= s_axis_tdata[26:19];
            hc   <= s_axis_tdata[34:27];
            snr  <= s_axis_tdata[42:35];
            rhop <= '0;
            status <= ST_MISS;
            best <= -9'sd1;
            idx  <= '0;
            state <= S_SCAN;
            case (s_axis_tdata[2:0])
              MODE_ADD: if (count >= DEPTH_C) begin
                status <= ST_FULL;
                state <= S_DONE;
              end
              MODE_CLEAR: begin
                count <= '0;
                status <= ST_OK;
                state <= S_DONE;
              end
              MODE_DEL, MODE_RENEW, MODE_FIRST, MODE_BEST: ;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          rvalid <= 1'b1;
          idx <= idx + 1'b1;
          if (rvalid) begin
            if (ridx >= count) begin
              state <= (mode == MODE_ADD) ? S_APP : S_DONE;
              idx <= count;
              rvalid <= 1'b0;
            end else begin
              case (mode)
                MODE_ADD: if (match_dh) begin
                  status <= (rdata.seq < seq) ? ST_UPD : ST_STALE;
                  state <= S_DONE;
                end
                MODE_DEL: if (match_dh) begin
                  status <= ST_OK;
                  count <= count - 1'b1;
                  idx <= ridx + 1'b1;
                  rvalid <= 1'b0;
                  state <= S_SHFT;
                end
                MODE_RENEW: if (match_ds) begin
                  status <= ST_OK;
                  state <= S_DONE;
                end
                MODE_FIRST: if (match_d) begin
                  status <= ST_OK;
                  rhop <= rdata.next;
                  state <= S_DONE;
                end
                MODE_BEST: if (match_d && $signed({rdata.quality[7], rdata.quality}) > best)
                begin
                  best <= $signed({rdata.quality[7], rdata.quality});
                  rhop <= rdata.next;
                  status <= ST_OK;
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_APP: begin
          rvalid <= 1'b1;
          if (rvalid) begin
            count <= count + 1'b1;
            status <= ST_OK;
            state <= S_DONE;
          end
        end
        S_SHFT: begin
          rvalid <= 1'b1;
          if (idx < DEPTH_C) idx <= idx + 1'b1;
          if (rvalid && ridx == DEPTH_C - 1'b1) state <= S_DONE;
          else if (!rvalid && idx >= DEPTH_C) state <= S_DONE;
        end
        S_DONE: begin
          rvalid <= 1'b0;
          cnt_out <= 6'(count);
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/route_checker.sv -----
module route_checker import rte_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_ready,
  input  wire logic [47:0] req_data,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_ready,
  input  wire logic [15:0] rsp_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // status in the lowest bits, as on the result bus
  typedef struct packed {
    logic [5:0] count;
    logic [7:0] hop;
    logic [1:0] status;
  } route_reply_t;

  route_t       tbl [DEPTH];
  int           live;
  route_reply_t replies_due [$];

  assign pending = replies_due.size();

  function automatic logic [7:0] mean_quality(logic [7:0] old_q, logic [7:0] snr);
    int s;
    s = ($signed(old_q) + $signed(snr)) / 2;
    return s[7:0];
  endfunction

  function automatic route_reply_t apply_request(logic [47:0] d);
    logic [2:0]   mode;
    logic [7:0]   dst, hop, seq, hc, snr;
    route_reply_t r;
    int           best, q;
    bit           hit;
    mode = d[2:0]; dst = d[10:3]; hop = d[18:11];
    seq = d[26:19]; hc = d[34:27]; snr = d[42:35];
    r.status = ST_MISS;
    r.hop = 8'd0;
    hit = 0;
    case (mode)
      MODE_ADD: begin
        if (live >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          for (int i = 0; i < live && !hit; i++) begin
            if (tbl[i].dest == dst && tbl[i].next == hop) begin
              hit = 1;
              if (tbl[i].seq < seq) begin
                tbl[i].seq = seq;
                tbl[i].hops = hc;
                tbl[i].quality = mean_quality(tbl[i].quality, snr);
                r.status = ST_UPD;
              end else begin
                r.status = ST_STALE;
              end
            end
          end
          if (!hit) begin
            tbl[live].dest = dst;
            tbl[live].next = hop;
            tbl[live].seq = seq;
            tbl[live].hops = hc;
            tbl[live].quality = mean_quality(tbl[live].quality, snr);
            live++;
          end
        end
      end
      MODE_DEL: begin
        for (int i = 0; i < live && !hit; i++) begin
          if (tbl[i].dest == dst && tbl[i].next == hop) begin
            hit = 1;
            for (int k = i; k < DEPTH - 1; k++) tbl[k] = tbl[k+1];
            live--;
            r.status = ST_OK;
          end
        end
      end
      MODE_RENEW: begin
        for (int i = 0; i < live && !hit; i++) begin
          if (tbl[i].dest == dst && tbl[i].seq == seq) begin
            hit = 1;
            tbl[i].life = FULL_LIFE;
            r.status = ST_OK;
          end
        end
      end
      MODE_FIRST: begin
        for (int i = 0; i < live && !hit; i++) begin
          if (tbl[i].dest == dst) begin
            hit = 1;
            r.hop = tbl[i].next;
            r.status = ST_OK;
          end
        end
      end
      MODE_BEST: begin
        best = -1;
        for (int i = 0; i < live; i++) begin
          q = $signed(tbl[i].quality);
          if (tbl[i].dest == dst && q > best) begin
            best = q;
            r.hop = tbl[i].next;
            r.status = ST_OK;
          end
        end
      end
      MODE_CLEAR: begin
        live = 0;
        r.status = ST_OK;
      end
      default: ;
    endcase
    r.count = live[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    route_reply_t want, got;
    int           errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) tbl[i] = '0;
      live = 0;
      replies_due.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (req_valid && req_ready) replies_due.push_back(apply_request(req_data));
      if (rsp_valid && rsp_ready) begin
        got = rsp_data;
        checked <= checked + 1;
        if (replies_due.size() == 0) begin
          $error("unexpected result %h", rsp_data);
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.hop !== want.hop) begin
            $error("route_hop: expected %0d, got %0d", want.hop, got.hop);
            errs++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
  end
endmodule

// ----- tb/tb.sv -----
module tb;
  import rte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // mode, dest, hop, seq, hops, snr, zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;       // status, route_hop, entry_count

  int  fail_count, pending, checked;
  int  cycle = 0;
  bit  hold_off = 0;  // long receiver stall requested by stimulus

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  route_table_engine DUT (.*);

  route_checker #(.DEPTH(32)) u_checker (
    .clk, .rst,
    .req_valid(s_axis_tvalid), .req_ready(s_axis_tready), .req_data(s_axis_tdata),
    .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp_data(m_axis_tdata),
    .fail_count, .pending, .checked
  );

  // watchdog; generous even for delete-heavy traffic, stalls and the clearing pass
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 900000) begin
      $display("timeout after %0d cycles", cycle);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern, stall-free stretches, and a long hold-off
  always @(posedge clk) begin
    int phase;
    phase = (cycle / 500) % 3;
    if (rst || hold_off) m_axis_tready <= 0;
    else if (phase == 0) m_axis_tready <= 1;
    else if (phase == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 3) == 0);
  end

  // small address pools so adds, deletes and lookups collide often
  function automatic logic [47:0] make_request(logic [2:0] mode, logic [7:0] dst,
      logic [7:0] hop, logic [7:0] seq, logic [7:0] hc, logic [7:0] snr);
    return {5'd0, snr, hc, seq, hop, dst, mode};
  endfunction

  function automatic logic [47:0] random_request();
    logic [2:0] mode;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) mode = MODE_ADD;
    else if (pick < 55) mode = MODE_DEL;
    else if (pick < 67) mode = MODE_RENEW;
    else if (pick < 80) mode = MODE_FIRST;
    else if (pick < 93) mode = MODE_BEST;
    else if (pick < 96) mode = MODE_CLEAR;
    else mode = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) == 0)
      return make_request(mode, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
    return make_request(mode, 8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
  endfunction

  // one request, held until the handshake, then valid is dropped before the next
  task automatic send(logic [47:0] d);
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int burst, fill_pos;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: misses on empty table, add/update/stale, extremes of snr
    send(make_request(MODE_FIRST, 8'd1, 0, 0, 0, 0));
    send(make_request(MODE_BEST, 8'd1, 0, 0, 0, 0));
    send(make_request(MODE_DEL, 8'd1, 8'd2, 0, 0, 0));
    send(make_request(MODE_RENEW, 8'd1, 0, 0, 0, 0));
    send(make_request(MODE_ADD, 8'hFF, 8'hFF, 8'd5, 8'hFF, 8'h7F));
    send(make_request(MODE_ADD, 8'hFF, 8'hFF, 8'd9, 8'd0, 8'h80));   // update
    send(make_request(MODE_ADD, 8'hFF, 8'hFF, 8'd9, 8'd1, 8'd3));    // stale
    send(make_request(MODE_ADD, 8'hFF, 8'd0, 8'hFF, 8'd1, 8'h81));   // negative quality
    send(make_request(MODE_ADD, 8'hFF, 8'd7, 8'd0, 8'd1, 8'd0));
    send(make_request(MODE_BEST, 8'hFF, 0, 0, 0, 0));
    send(make_request(MODE_FIRST, 8'hFF, 0, 0, 0, 0));
    send(make_request(MODE_RENEW, 8'hFF, 0, 8'hFF, 0, 0));
    send(make_request(MODE_DEL, 8'hFF, 8'hFF, 0, 0, 0));
    send(make_request(MODE_ADD, 8'h00, 8'd0, 8'd1, 8'd1, 8'hFF));    // odd negative sum
    send(make_request(3'd6, 8'd1, 0, 0, 0, 0));
    send(make_request(3'd7, 8'd1, 0, 0, 0, 0));
    send(make_request(MODE_CLEAR, 0, 0, 0, 0, 0));
    send(make_request(MODE_ADD, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3));      // reuses stale quality
    drain();

    // fill past capacity while the receiver holds off; then full-table adds
    hold_off = 1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 0; end
    join_none
    for (fill_pos = 0; fill_pos < 36; fill_pos++)
      send(make_request(MODE_ADD, fill_pos[7:0], 8'd9, 8'd1, fill_pos[7:0], 8'($urandom)));
    send(make_request(MODE_ADD, 8'd0, 8'd9, 8'd2, 0, 0));            // full, match ignored
    send(make_request(MODE_DEL, 8'd31, 8'd9, 0, 0, 0));               // miss: the add of dest 31 found the table full
    send(make_request(MODE_DEL, 8'd0, 8'd9, 0, 0, 0));               // second slot
    drain();

    // random bursts with gaps
    for (int n = 0; n < 1900; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) send(random_request());
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Route table: directed add/delete/renew/lookups/clear, full table under a");
    $display("long output stall, then random bursts; %0d results checked.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
